/* rtl/core/two_level_bucket_priority_queue_defines.svh */
// assertion macros for the two-level bucket priority queue
// no dependencies; included by the files that carry assertions
`ifndef TWO_LEVEL_BUCKET_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_LEVEL_BUCKET_PRIORITY_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLBQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlbq assertion failed");
// next-cycle implication
`define TLBQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tlbq assertion failed");
`else
`define TLBQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TLBQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/tlbq_pkg.sv */
// shared types and constants of the bucket priority queue
// no dependencies
package tlbq_pkg;
    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 10;
    localparam int KEY_W    = 12;

    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_PUSH  = 2'd0;
    localparam t_action ACT_POP   = 2'd1;
    localparam t_action ACT_QUERY = 2'd2;
endpackage

/* rtl/core/tlbq_channels.sv */
// request and response channel interfaces of the bucket priority queue
// depends on tlbq_pkg
interface tlbq_req_if import tlbq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] node_handle;
    logic [KEY_W-1:0]    key_priority;
    modport source (output valid, action, node_handle, key_priority, input ready);
    modport sink (input valid, action, node_handle, key_priority, output ready);
endinterface

interface tlbq_rsp_if import tlbq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] popped_handle;
    logic                found;
    logic                is_member;
    logic                queue_empty;
    logic                overflow;
    modport source (output valid, popped_handle, found, is_member, queue_empty, overflow,
                    input ready);
    modport sink (input valid, popped_handle, found, is_member, queue_empty, overflow,
                  output ready);
endinterface

/* rtl/core/tlbq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module tlbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/two_level_bucket_priority_queue.sv */
// two-level bucket priority queue with lazy decrease-key
// depends on tlbq_pkg, tlbq_channels, tlbq_ram and the defines header
//
// usage
//   i_req carries one item: action (push / pop minimum / membership query),
//   node_handle and key_priority. o_rsp returns exactly one result item per
//   request item: popped_handle, found, is_member, queue_empty, overflow.
//   both channels use valid/ready; an item moves when both are high.
// sequence
//   push and query read a ram before the result register is loaded;
//   dropped or ignored push, no-op and pop of an empty queue go straight to finish.
//   pop reads the bucket head, then the entry, then the handle table for a
//   live entry at the cursor, stepping over empty buckets and discarding
//   stale entries; the loop follows the bucket head ram and entry ram reads.
//   one item is in work at a time; the next is taken once its result is loaded.
// reset
//   i_rst_n is synchronous; after it a clearing pass over
//   max(NUM_NODES, NUM_BUCKETS) addresses (4096 at default) writes the handle
//   table to absent and every bucket head to empty; no item is accepted then.
//   the entry store is not cleared: a fresh-entry counter hands out entries
//   never used, recycled entries go on a linked free list.
// stall
//   a finished result waits in the output register; a completed item holds
//   in its finish state until the output register is free.
`include "two_level_bucket_priority_queue_defines.svh"

module two_level_bucket_priority_queue import tlbq_pkg::*; #(
    parameter int PRIORITY_BITS  = 12,
    parameter int SLOT_BITS      = 6,
    parameter int NUM_NODES      = 1024,
    parameter int ENTRY_CAPACITY = 4096
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tlbq_req_if.sink   i_req,
    tlbq_rsp_if.source o_rsp
);
    // geometry
    localparam int NUM_SLOTS   = 1 << SLOT_BITS;
    localparam int NUM_GROUPS  = ((1 << PRIORITY_BITS) + NUM_SLOTS - 1) >> SLOT_BITS;
    localparam int NUM_BUCKETS = NUM_GROUPS * NUM_SLOTS;
    localparam int BW          = $clog2(NUM_BUCKETS);
    localparam int NW          = $clog2(NUM_NODES);
    localparam int EW          = $clog2(ENTRY_CAPACITY);
    localparam int LW          = $clog2(ENTRY_CAPACITY + 1);
    localparam int GW          = $clog2(NUM_GROUPS + 1);
    localparam int RW          = PRIORITY_BITS + 1;
    localparam int ENW         = HANDLE_W + LW;
    localparam int CLR_N       = (NUM_NODES > NUM_BUCKETS) ? NUM_NODES : NUM_BUCKETS;
    localparam int CW          = $clog2(CLR_N + 1);
    localparam logic [LW-1:0] NIL      = LW'(ENTRY_CAPACITY);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_PUSH_WR  = 9'b000000100,
        S_QUERY    = 9'b000001000,
        S_POP_SCAN = 9'b000010000,
        S_POP_HEAD = 9'b000100000,
        S_POP_ENT  = 9'b001000000,
        S_POP_REF  = 9'b010000000,
        S_FIN      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [HANDLE_W-1:0]      r_handle, n_handle;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic [BW-1:0]            r_bucket, n_bucket;
    logic [LW-1:0]            r_entry, n_entry;
    logic [LW-1:0]            r_free_head, n_free_head;
    logic [LW-1:0]            r_fresh, n_fresh;
    logic [LW-1:0]            r_count, n_count;
    logic [GW-1:0]            r_scan_group, n_scan_group;
    logic [SLOT_BITS-1:0]     r_scan_slot, n_scan_slot;
    logic [CW-1:0]            r_clr, n_clr;
    logic [HANDLE_W-1:0]      r_res_popped, n_res_popped;
    logic                     r_res_found, n_res_found;
    logic                     r_res_member, n_res_member;
    logic                     r_res_ovf, n_res_ovf;
    logic                     r_o_valid, n_o_valid;
    logic [HANDLE_W-1:0]      r_o_popped;
    logic                     r_o_found, r_o_member, r_o_empty, r_o_ovf;
    logic                     load_out;

    // memory ports
    logic          ref_we, bkt_we, ent_we;
    logic [NW-1:0] ref_waddr, ref_raddr;
    logic [RW-1:0] ref_wdata, ref_rdata;
    logic [BW-1:0] bkt_waddr, bkt_raddr;
    logic [LW-1:0] bkt_wdata, bkt_rdata;
    logic [EW-1:0] ent_waddr, ent_raddr;
    logic [ENW-1:0] ent_wdata, ent_rdata;

    // handle table: valid bit and recorded priority
    tlbq_ram #(.WIDTH(RW), .DEPTH(NUM_NODES)) u_ref_ram (
        .i_clk(i_clk), .i_we(ref_we), .i_waddr(ref_waddr), .i_wdata(ref_wdata),
        .i_raddr(ref_raddr), .o_rdata(ref_rdata)
    );
    // top entry of each bucket stack
    tlbq_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_waddr), .i_wdata(bkt_wdata),
        .i_raddr(bkt_raddr), .o_rdata(bkt_rdata)
    );
    // entry store: handle and link
    tlbq_ram #(.WIDTH(ENW), .DEPTH(ENTRY_CAPACITY)) u_ent_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    // request decode
    logic [31:0]              in_h32, in_p32, in_k32, r_h32, r_p32, cur_b32;
    logic                     in_h_ok;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic [HANDLE_W-1:0]      ent_handle;
    logic [LW-1:0]            ent_link;
    logic [31:0]              ent_h32;
    logic [LW-1:0]            new_entry;

    always_comb begin
        in_h32  = 32'(i_req.node_handle);
        in_k32  = 32'(i_req.key_priority);
        in_prio = in_k32[PRIORITY_BITS-1:0];
        in_p32  = 32'(in_prio);
        in_h_ok = (in_h32 < NUM_NODES);
        r_h32   = 32'(r_handle);
        r_p32   = 32'(r_prio);
        cur_b32 = (32'(r_scan_group) << SLOT_BITS) | 32'(r_scan_slot);
        ent_handle = ent_rdata[ENW-1:LW];
        ent_link   = ent_rdata[LW-1:0];
        ent_h32    = 32'(ent_handle);
        new_entry  = (r_free_head == NIL) ? r_fresh : r_free_head;
    end

    assign load_out = (r_state == S_FIN) && (!r_o_valid || o_rsp.ready);

    always_comb begin
        n_state      = r_state;
        n_handle     = r_handle;
        n_prio       = r_prio;
        n_bucket     = r_bucket;
        n_entry      = r_entry;
        n_free_head  = r_free_head;
        n_fresh      = r_fresh;
        n_count      = r_count;
        n_scan_group = r_scan_group;
        n_scan_slot  = r_scan_slot;
        n_clr        = r_clr;
        n_res_popped = r_res_popped;
        n_res_found  = r_res_found;
        n_res_member = r_res_member;
        n_res_ovf    = r_res_ovf;
        ref_we = 1'b0; ref_waddr = '0; ref_wdata = '0; ref_raddr = '0;
        bkt_we = 1'b0; bkt_waddr = '0; bkt_wdata = '0; bkt_raddr = '0;
        ent_we = 1'b0; ent_waddr = '0; ent_wdata = '0; ent_raddr = '0;

        unique case (r_state)
            S_CLEAR: begin
                if (32'(r_clr) < NUM_NODES) begin
                    ref_we    = 1'b1;
                    ref_waddr = r_clr[NW-1:0];
                end
                if (32'(r_clr) < NUM_BUCKETS) begin
                    bkt_we    = 1'b1;
                    bkt_waddr = r_clr[BW-1:0];
                    bkt_wdata = NIL;
                end
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_handle     = i_req.node_handle;
                    n_prio       = in_prio;
                    n_res_popped = '0;
                    n_res_found  = 1'b0;
                    n_res_member = 1'b0;
                    n_res_ovf    = 1'b0;
                    n_state      = S_FIN;
                    case (i_req.action)
                        ACT_PUSH: begin
                            if (in_h_ok && 32'(r_count) >= ENTRY_CAPACITY) begin
                                n_res_ovf = 1'b1;
                            end else if (in_h_ok) begin
                                bkt_raddr = in_p32[BW-1:0];
                                ent_raddr = r_free_head[EW-1:0];
                                n_state   = S_PUSH_WR;
                            end
                        end
                        ACT_POP: begin
                            if (r_count != '0) begin
                                n_state = S_POP_SCAN;
                            end
                        end
                        ACT_QUERY: begin
                            if (in_h_ok) begin
                                ref_raddr = in_h32[NW-1:0];
                                n_state   = S_QUERY;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_PUSH_WR: begin
                // take an entry: recycled one first, otherwise a never-used one
                if (r_free_head == NIL) begin
                    n_fresh = r_fresh + 1'b1;
                end else begin
                    n_free_head = ent_link;
                end
                ent_we    = 1'b1;
                ent_waddr = new_entry[EW-1:0];
                ent_wdata = {r_handle, bkt_rdata};
                bkt_we    = 1'b1;
                bkt_waddr = r_p32[BW-1:0];
                bkt_wdata = new_entry;
                ref_we    = 1'b1;
                ref_waddr = r_h32[NW-1:0];
                ref_wdata = {1'b1, r_prio};
                n_count   = r_count + 1'b1;
                if ((r_p32 >> SLOT_BITS) < 32'(r_scan_group)) begin
                    n_scan_group = GW'(r_p32 >> SLOT_BITS);
                    n_scan_slot  = r_p32[SLOT_BITS-1:0];
                end else if ((r_p32 >> SLOT_BITS) == 32'(r_scan_group)
                             && r_p32[SLOT_BITS-1:0] < r_scan_slot) begin
                    n_scan_slot = r_p32[SLOT_BITS-1:0];
                end
                n_state = S_FIN;
            end
            S_QUERY: begin
                n_res_member = ref_rdata[RW-1];
                n_state      = S_FIN;
            end
            S_POP_SCAN: begin
                if (32'(r_scan_group) >= NUM_GROUPS) begin
                    n_state = S_FIN;
                end else begin
                    bkt_raddr = cur_b32[BW-1:0];
                    n_bucket  = cur_b32[BW-1:0];
                    n_state   = S_POP_HEAD;
                end
            end
            S_POP_HEAD: begin
                if (bkt_rdata == NIL) begin
                    // empty bucket, step the cursor
                    if (32'(r_scan_slot) == NUM_SLOTS - 1) begin
                        n_scan_slot  = '0;
                        n_scan_group = r_scan_group + 1'b1;
                    end else begin
                        n_scan_slot = r_scan_slot + 1'b1;
                    end
                    n_state = S_POP_SCAN;
                end else begin
                    n_entry   = bkt_rdata;
                    ent_raddr = bkt_rdata[EW-1:0];
                    n_state   = S_POP_ENT;
                end
            end
            S_POP_ENT: begin
                // unlink the top entry and put it on the free list
                bkt_we      = 1'b1;
                bkt_waddr   = r_bucket;
                bkt_wdata   = ent_link;
                ent_we      = 1'b1;
                ent_waddr   = r_entry[EW-1:0];
                ent_wdata   = {ent_handle, r_free_head};
                n_free_head = r_entry;
                n_count     = r_count - 1'b1;
                n_handle    = ent_handle;
                if (ent_h32 < NUM_NODES) begin
                    ref_raddr = ent_h32[NW-1:0];
                    n_state   = S_POP_REF;
                end else begin
                    n_state = S_POP_SCAN;
                end
            end
            S_POP_REF: begin
                // live only if the recorded priority still names this bucket
                if (ref_rdata[RW-1]
                    && 32'(ref_rdata[PRIORITY_BITS-1:0]) == 32'(r_bucket)) begin
                    ref_we       = 1'b1;
                    ref_waddr    = r_h32[NW-1:0];
                    ref_wdata    = '0;
                    n_res_found  = 1'b1;
                    n_res_popped = r_handle;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_POP_SCAN;
                end
            end
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (o_rsp.ready) begin
            n_o_valid = 1'b0;
        end
        if (load_out) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_free_head  <= NIL;
            r_fresh      <= '0;
            r_count      <= '0;
            r_scan_group <= GW'(NUM_GROUPS);
            r_scan_slot  <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_free_head  <= n_free_head;
            r_fresh      <= n_fresh;
            r_count      <= n_count;
            r_scan_group <= n_scan_group;
            r_scan_slot  <= n_scan_slot;
            r_o_valid    <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_handle     <= n_handle;
        r_prio       <= n_prio;
        r_bucket     <= n_bucket;
        r_entry      <= n_entry;
        r_res_popped <= n_res_popped;
        r_res_found  <= n_res_found;
        r_res_member <= n_res_member;
        r_res_ovf    <= n_res_ovf;
        if (load_out) begin
            r_o_popped <= r_res_popped;
            r_o_found  <= r_res_found;
            r_o_member <= r_res_member;
            r_o_empty  <= (r_count == '0);
            r_o_ovf    <= r_res_ovf;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.popped_handle = r_o_popped;
    assign o_rsp.found         = r_o_found;
    assign o_rsp.is_member     = r_o_member;
    assign o_rsp.queue_empty   = r_o_empty;
    assign o_rsp.overflow      = r_o_ovf;

    // the clearing pass takes no item
    `TLBQ_ASSERT_IMPL(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLEAR, !i_req.ready)
    // stored entries never exceed the store
    `TLBQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= ENTRY_CAPACITY)
    // an accepted push that writes counts exactly one entry
    `TLBQ_ASSERT_NEXT(a_push_cnt, i_clk, i_rst_n, r_state == S_PUSH_WR, r_count == $past(r_count) + 1'b1)
endmodule

/* tb/sv/two_level_bucket_priority_queue_test.sv */
// self-checking testbench of the two-level bucket priority queue
// depends on tlbq_pkg, tlbq_channels and two_level_bucket_priority_queue
`timescale 1ns / 1ps

module two_level_bucket_priority_queue_test;
    import tlbq_pkg::*;

    localparam int SLOT_BITS   = 6;
    localparam int NODES       = 1024;
    localparam int CAPACITY    = 4096;
    localparam int NUM_SLOTS   = 1 << SLOT_BITS;
    localparam int NUM_GROUPS  = 4096 / NUM_SLOTS;
    localparam int NUM_BUCKETS = NUM_GROUPS * NUM_SLOTS;
    localparam int NIL         = CAPACITY;
    localparam int WATCH_LIMIT = 40000;
    localparam int N_RANDOM    = 1130;

    typedef struct packed {
        logic [HANDLE_W-1:0] popped_handle;
        logic                found;
        logic                is_member;
        logic                queue_empty;
        logic                overflow;
    } t_result;

    typedef struct {
        t_action             act;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        bit                  typed;
        t_result             res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    tlbq_req_if req ();
    tlbq_rsp_if rsp ();

    two_level_bucket_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    // predictor state
    bit              hq_valid [NODES];
    int unsigned     hq_prio  [NODES];
    int unsigned     head     [NUM_BUCKETS];
    int unsigned     e_handle [CAPACITY];
    int unsigned     e_link   [CAPACITY];
    int unsigned     free_top, n_entries, cur_group, cur_slot;

    t_result     pending_results [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    task automatic queue_reset();
        for (int i = 0; i < NODES; i++) begin
            hq_valid[i] = 0;
            hq_prio[i] = 0;
        end
        for (int i = 0; i < NUM_BUCKETS; i++) head[i] = NIL;
        for (int i = 0; i < CAPACITY; i++) begin
            e_handle[i] = 0;
            e_link[i] = i + 1;
        end
        free_top = 0;
        n_entries = 0;
        cur_group = NUM_GROUPS;
        cur_slot = 0;
    endtask

    function automatic t_result queue_step(t_action act, int unsigned h, int unsigned k);
        t_result     r;
        int unsigned g, s, b, e, eh;
        bit          done;
        r = '0;
        if (act == ACT_PUSH) begin
            if (h < NODES) begin
                if (n_entries >= CAPACITY || free_top >= NIL) begin
                    r.overflow = 1'b1;
                end else begin
                    g = k >> SLOT_BITS;
                    s = k & (NUM_SLOTS - 1);
                    b = k;
                    e = free_top;
                    free_top = e_link[e];
                    e_handle[e] = h;
                    e_link[e] = head[b];
                    head[b] = e;
                    hq_valid[h] = 1;
                    hq_prio[h] = k;
                    n_entries++;
                    if (g < cur_group) begin
                        cur_group = g;
                        cur_slot = s;
                    end else if (g == cur_group && s < cur_slot) begin
                        cur_slot = s;
                    end
                end
            end
        end else if (act == ACT_POP) begin
            done = 0;
            if (n_entries != 0) begin
                while (!done && cur_group < NUM_GROUPS) begin
                    b = (cur_group << SLOT_BITS) | cur_slot;
                    e = head[b];
                    if (e < NIL) begin
                        eh = e_handle[e];
                        head[b] = e_link[e];
                        e_link[e] = free_top;
                        free_top = e;
                        n_entries--;
                        if (eh < NODES && hq_valid[eh] && hq_prio[eh] == b) begin
                            hq_valid[eh] = 0;
                            hq_prio[eh] = 0;
                            r.popped_handle = HANDLE_W'(eh);
                            r.found = 1'b1;
                            done = 1;
                        end
                    end else begin
                        cur_slot++;
                        if (cur_slot >= NUM_SLOTS) begin
                            cur_slot = 0;
                            cur_group++;
                        end
                    end
                end
            end
        end else if (act == ACT_QUERY) begin
            r.is_member = (h < NODES) && hq_valid[h];
        end
        r.queue_empty = (n_entries == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // drive one item; the expectation is queued once it has been accepted
    task automatic send_item(t_action act, int unsigned h, int unsigned k,
                             bit typed, t_result want);
        t_result r;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.node_handle <= HANDLE_W'(h);
        req.key_priority <= KEY_W'(k);
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        r = queue_step(act, h, k);
        if (typed && r !== want) report_mismatch("typed row", int'(r), int'(want));
        pending_results = {pending_results, r};
        @(negedge i_clk);
    endtask

    // receiver: random stalls, field-by-field compare
    always @(negedge i_clk) begin
        if (!i_rst_n) rsp.ready <= 1'b0;
        else rsp.ready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (rsp.popped_handle !== want.popped_handle)
                    report_mismatch("popped_handle", int'(rsp.popped_handle),
                                    int'(want.popped_handle));
                if (rsp.found !== want.found)
                    report_mismatch("found", int'(rsp.found), int'(want.found));
                if (rsp.is_member !== want.is_member)
                    report_mismatch("is_member", int'(rsp.is_member), int'(want.is_member));
                if (rsp.queue_empty !== want.queue_empty)
                    report_mismatch("queue_empty", int'(rsp.queue_empty),
                                    int'(want.queue_empty));
                if (rsp.overflow !== want.overflow)
                    report_mismatch("overflow", int'(rsp.overflow), int'(want.overflow));
            end
        end
    end

    // watchdog on cycles with no handshake (covers the clearing pass too)
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("two_level_bucket_priority_queue verification failed");
            $finish;
        end
    end

    function automatic t_result mk(int unsigned ph, int unsigned f, int unsigned m,
                                   int unsigned qe, int unsigned ov);
        t_result r;
        r = '{popped_handle: HANDLE_W'(ph), found: 1'(f), is_member: 1'(m),
              queue_empty: 1'(qe), overflow: 1'(ov)};
        return r;
    endfunction

    t_row dir_rows [$];

    task automatic add_row(t_action a, int unsigned h, int unsigned k, bit typed, t_result r);
        t_row x;
        x.act = a;
        x.handle = HANDLE_W'(h);
        x.key = KEY_W'(k);
        x.typed = typed;
        x.res = r;
        dir_rows = {dir_rows, x};
    endtask

    // random item: mostly pushes and pops on a small handle set, with queries and occasional no-op actions
    task automatic random_item(int phase);
        int unsigned sel, h, k;
        t_action     a;
        sel = $urandom_range(99, 0);
        h = (sel < 90) ? $urandom_range(63, 0) : $urandom_range(1023, 0);
        if (phase % 2 == 0) k = $urandom_range(4095, 0);
        else k = $urandom_range(300, 0);
        if (sel < 45) a = ACT_PUSH;
        else if (sel < 80) a = ACT_POP;
        else if (sel < 97) a = ACT_QUERY;
        else a = t_action'(2'd3);
        send_item(a, h, k, 1'b0, '0);
    endtask

    initial begin
        queue_reset();
        req.valid = 1'b0;
        req.action = ACT_PUSH;
        req.node_handle = '0;
        req.key_priority = '0;
        rsp.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: extremes, stale entries, empty pop, odd actions
        add_row(ACT_POP,   0,    0,    1, mk(0, 0, 0, 1, 0));
        add_row(ACT_QUERY, 1023, 0,    1, mk(0, 0, 0, 1, 0));
        add_row(t_action'(2'd3), 1023, 4095, 1, mk(0, 0, 0, 1, 0));
        add_row(ACT_PUSH,  1023, 4095, 1, mk(0, 0, 0, 0, 0));
        add_row(ACT_QUERY, 1023, 0,    1, mk(0, 0, 1, 0, 0));
        add_row(ACT_PUSH,  0,    0,    1, mk(0, 0, 0, 0, 0));
        add_row(ACT_POP,   0,    0,    1, mk(0, 1, 0, 0, 0));
        add_row(ACT_POP,   0,    0,    1, mk(1023, 1, 0, 1, 0));
        add_row(ACT_PUSH,  5,    700,  0, '0);
        add_row(ACT_PUSH,  5,    100,  0, '0);   // decrease key leaves a stale entry
        add_row(ACT_PUSH,  6,    100,  0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);   // only stale left
        add_row(ACT_QUERY, 5,    0,    0, '0);
        add_row(ACT_PUSH,  7,    63,   0, '0);
        add_row(ACT_PUSH,  8,    64,   0, '0);
        add_row(ACT_PUSH,  9,    2730, 0, '0);
        add_row(ACT_PUSH,  10,   1365, 0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);
        add_row(ACT_POP,   0,    0,    0, '0);
        add_row(ACT_QUERY, 682,  0,    0, '0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].handle, dir_rows[i].key,
                      dir_rows[i].typed, dir_rows[i].res);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) random_item(phase);
        end
        req.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("two_level_bucket_priority_queue verification clean");
        else
            $display("two_level_bucket_priority_queue verification failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tlbq_pkg.sv
rtl/core/tlbq_channels.sv
rtl/core/tlbq_ram.sv
rtl/core/two_level_bucket_priority_queue.sv
tb/sv/two_level_bucket_priority_queue_test.sv
